### sv/assert_macros.svh
// Assertion macros shared by the mode controller RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check a same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check an implication in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/gumc_pkg.sv
// Shared types, codes and helpers for the UI mode controller.
// No dependencies; imported by the register file, the core and the top level.
package gumc_pkg;

   // Register file geometry
   localparam int DATA_W = 32;
   localparam int ADDR_W = 5;

   // Command codes
   localparam logic [2:0] CMD_INIT       = 3'd0;
   localparam logic [2:0] CMD_BUTTON     = 3'd1;
   localparam logic [2:0] CMD_TICK       = 3'd2;
   localparam logic [2:0] CMD_SONG_END   = 3'd3;
   localparam logic [2:0] CMD_SONG_ERROR = 3'd4;
   localparam logic [2:0] CMD_TAKE_DIRTY = 3'd5;

   // Button codes
   localparam logic [1:0] BTN_A = 2'd0;
   localparam logic [1:0] BTN_B = 2'd1;

   // Audio request codes
   localparam logic [1:0] AUD_NONE   = 2'd0;
   localparam logic [1:0] AUD_START  = 2'd1;
   localparam logic [1:0] AUD_PAUSE  = 2'd2;
   localparam logic [1:0] AUD_RESUME = 2'd3;

   // Song state codes
   localparam logic [1:0] SONG_IDLE    = 2'd0;
   localparam logic [1:0] SONG_PLAYING = 2'd1;
   localparam logic [1:0] SONG_PAUSED  = 2'd2;

   // Repaint flag bit positions
   localparam int FLAG_SCREEN  = 0;
   localparam int FLAG_CUE     = 1;
   localparam int FLAG_THEME   = 2;
   localparam int FLAG_EYE     = 3;
   localparam int FLAG_BANNER  = 4;
   localparam int FLAG_DETAILS = 5;

   // Register indexes
   localparam logic [2:0] REG_MUTE             = 3'd0;
   localparam logic [2:0] REG_WINK_PERIOD      = 3'd1;
   localparam logic [2:0] REG_WINK_HOLD        = 3'd2;
   localparam logic [2:0] REG_BANNER_INTERVAL  = 3'd3;
   localparam logic [2:0] REG_DETAILS_INTERVAL = 3'd4;

   // Register reset values
   localparam logic [15:0] RST_WINK_PERIOD      = 16'd4000;
   localparam logic [15:0] RST_WINK_HOLD        = 16'd150;
   localparam logic [15:0] RST_BANNER_INTERVAL  = 16'd200;
   localparam logic [15:0] RST_DETAILS_INTERVAL = 16'd100;

   typedef struct packed {
      logic        mute;
      logic [15:0] wink_period;
      logic [15:0] wink_hold;
      logic [15:0] banner_interval;
      logic [15:0] details_interval;
   } gumc_cfg_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [1:0]  button;
      logic [31:0] now_ms;
   } gumc_item_type;

   typedef struct packed {
      logic [1:0]  audio_request;
      logic [5:0]  repaint_flags;
      logic        screen_now;
      logic [1:0]  theme_now;
      logic [1:0]  song_now;
      logic        eye_shut;
      logic        start_refused;
      logic [15:0] banner_position;
   } gumc_rsp_type;

   // A deadline is due once now has reached it, modulo half the time range
   function automatic logic is_due(logic [31:0] now, logic [31:0] at);
      logic [31:0] diff;
      diff = now - at;
      return ~diff[31];
   endfunction

endpackage

### sv/gumc_csr.sv
// Configuration register file of the UI mode controller (APB-style port).
// Depends on gumc_pkg for register indexes, reset values and the config struct.
module gumc_csr
   import gumc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output gumc_cfg_type      cfg
);

   gumc_cfg_type cfg_ff;
   gumc_cfg_type cfg_in;
   logic [2:0]   index;
   logic         write_en;

   assign index      = csr_paddr[4:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Decode the write transaction
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_MUTE:             cfg_in.mute             = csr_pwdata[0];
            REG_WINK_PERIOD:      cfg_in.wink_period      = csr_pwdata[15:0];
            REG_WINK_HOLD:        cfg_in.wink_hold        = csr_pwdata[15:0];
            REG_BANNER_INTERVAL:  cfg_in.banner_interval  = csr_pwdata[15:0];
            REG_DETAILS_INTERVAL: cfg_in.details_interval = csr_pwdata[15:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (index)
         REG_MUTE:             csr_prdata = DATA_W'(cfg_ff.mute);
         REG_WINK_PERIOD:      csr_prdata = DATA_W'(cfg_ff.wink_period);
         REG_WINK_HOLD:        csr_prdata = DATA_W'(cfg_ff.wink_hold);
         REG_BANNER_INTERVAL:  csr_prdata = DATA_W'(cfg_ff.banner_interval);
         REG_DETAILS_INTERVAL: csr_prdata = DATA_W'(cfg_ff.details_interval);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mute             <= 1'b0;
         cfg_ff.wink_period      <= RST_WINK_PERIOD;
         cfg_ff.wink_hold        <= RST_WINK_HOLD;
         cfg_ff.banner_interval  <= RST_BANNER_INTERVAL;
         cfg_ff.details_interval <= RST_DETAILS_INTERVAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/gumc_core.sv
// State and single-pass update logic of the UI mode controller.
// Depends on gumc_pkg and assert_macros.svh; driven by the top level's input stage.
`include "assert_macros.svh"
module gumc_core
   import gumc_pkg::*;
#(
   parameter int THEME_COUNT = 4
)(
   input  logic          clock,
   input  logic          reset,
   input  gumc_cfg_type  cfg,
   input  logic          en,
   input  gumc_item_type item,
   output gumc_rsp_type  rsp
);

   localparam int THEME_W = (THEME_COUNT > 1) ? $clog2(THEME_COUNT) : 1;
   localparam logic [THEME_W-1:0] THEME_LAST = THEME_W'(THEME_COUNT - 1);

   logic               screen_ff, screen_in;
   logic [THEME_W-1:0] theme_ff, theme_in;
   logic [1:0]         song_ff, song_in;
   logic               blocked_ff, blocked_in;
   logic               eye_ff, eye_in;
   logic [15:0]        banner_cnt_ff, banner_cnt_in;
   logic [31:0]        wink_dl_ff, wink_dl_in;
   logic [31:0]        reopen_dl_ff, reopen_dl_in;
   logic [31:0]        banner_dl_ff, banner_dl_in;
   logic [31:0]        details_dl_ff, details_dl_in;
   logic [5:0]         pending_ff, pending_in;
   logic [1:0]         audio;
   logic [5:0]         flags;
   logic [15:0]        theme_wide;
   logic [31:0]        now;

   assign now = item.now_ms;

   // Apply one command to the state
   always_comb begin
      screen_in     = screen_ff;
      theme_in      = theme_ff;
      song_in       = song_ff;
      blocked_in    = blocked_ff;
      eye_in        = eye_ff;
      banner_cnt_in = banner_cnt_ff;
      wink_dl_in    = wink_dl_ff;
      reopen_dl_in  = reopen_dl_ff;
      banner_dl_in  = banner_dl_ff;
      details_dl_in = details_dl_ff;
      pending_in    = pending_ff;
      audio         = AUD_NONE;
      flags         = '0;
      unique case (item.command) inside
         CMD_INIT: begin
            screen_in     = 1'b0;
            theme_in      = '0;
            song_in       = SONG_IDLE;
            blocked_in    = 1'b0;
            eye_in        = 1'b0;
            banner_cnt_in = '0;
            wink_dl_in    = now + 32'(cfg.wink_period);
            reopen_dl_in  = '0;
            banner_dl_in  = now + 32'(cfg.banner_interval);
            details_dl_in = now;
            pending_in    = '0;
            pending_in[FLAG_SCREEN] = 1'b1;
         end
         CMD_BUTTON: begin
            case (item.button)
               BTN_A: begin
                  if (screen_ff) begin
                     screen_in = 1'b0;
                     pending_in[FLAG_SCREEN] = 1'b1;
                  end else if (song_ff == SONG_PLAYING) begin
                     song_in = SONG_PAUSED;
                     pending_in[FLAG_CUE] = 1'b1;
                     audio = AUD_PAUSE;
                  end else begin
                     theme_in = (theme_ff == THEME_LAST) ? '0 : theme_ff + THEME_W'(1);
                     pending_in[FLAG_THEME] = 1'b1;
                  end
               end
               BTN_B: begin
                  if (song_ff == SONG_IDLE) begin
                     if (cfg.mute) begin
                        blocked_in = 1'b1;
                     end else begin
                        song_in = SONG_PLAYING;
                        pending_in[FLAG_CUE] = 1'b1;
                        audio = AUD_START;
                     end
                  end else if (song_ff == SONG_PLAYING) begin
                     song_in = SONG_PAUSED;
                     pending_in[FLAG_CUE] = 1'b1;
                     audio = AUD_PAUSE;
                  end else begin
                     song_in = SONG_PLAYING;
                     pending_in[FLAG_CUE] = 1'b1;
                     audio = AUD_RESUME;
                  end
               end
               default: begin
                  // Button C and unused codes open details from the face
                  if (!screen_ff) begin
                     screen_in = 1'b1;
                     pending_in[FLAG_SCREEN] = 1'b1;
                  end
               end
            endcase
         end
         CMD_TICK: begin
            // Wink: shut on the wink deadline, reopen on the hold deadline
            if (!eye_ff && is_due(now, wink_dl_ff)) begin
               eye_in       = 1'b1;
               reopen_dl_in = now + 32'(cfg.wink_hold);
               wink_dl_in   = now + 32'(cfg.wink_period);
               if (!screen_ff) pending_in[FLAG_EYE] = 1'b1;
            end else if (eye_ff && is_due(now, reopen_dl_ff)) begin
               eye_in = 1'b0;
               if (!screen_ff) pending_in[FLAG_EYE] = 1'b1;
            end
            // Banner scroll step
            if (is_due(now, banner_dl_ff)) begin
               banner_cnt_in = banner_cnt_ff + 16'd1;
               banner_dl_in  = now + 32'(cfg.banner_interval);
               if (!screen_ff) pending_in[FLAG_BANNER] = 1'b1;
            end
            // Details refresh mark
            if (screen_ff && is_due(now, details_dl_ff)) begin
               details_dl_in = now + 32'(cfg.details_interval);
               pending_in[FLAG_DETAILS] = 1'b1;
            end
         end
         CMD_SONG_END, CMD_SONG_ERROR: begin
            song_in = SONG_IDLE;
            pending_in[FLAG_CUE] = 1'b1;
         end
         CMD_TAKE_DIRTY: begin
            flags      = pending_ff;
            pending_in = '0;
         end
         default: begin
            flags = '0;
         end
      endcase
   end

   // Build the result from the updated state
   assign theme_wide = 16'(theme_in);
   always_comb begin
      rsp.audio_request   = audio;
      rsp.repaint_flags   = flags;
      rsp.screen_now      = screen_in;
      rsp.theme_now       = theme_wide[1:0];
      rsp.song_now        = song_in;
      rsp.eye_shut        = eye_in;
      rsp.start_refused   = blocked_in;
      rsp.banner_position = banner_cnt_in;
   end

   // Commit the state when the transaction moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_ff     <= 1'b0;
         theme_ff      <= '0;
         song_ff       <= SONG_IDLE;
         blocked_ff    <= 1'b0;
         eye_ff        <= 1'b0;
         banner_cnt_ff <= '0;
         wink_dl_ff    <= 32'(RST_WINK_PERIOD);
         reopen_dl_ff  <= '0;
         banner_dl_ff  <= 32'(RST_BANNER_INTERVAL);
         details_dl_ff <= '0;
         pending_ff    <= 6'(1) << FLAG_SCREEN;
      end else if (en) begin
         screen_ff     <= screen_in;
         theme_ff      <= theme_in;
         song_ff       <= song_in;
         blocked_ff    <= blocked_in;
         eye_ff        <= eye_in;
         banner_cnt_ff <= banner_cnt_in;
         wink_dl_ff    <= wink_dl_in;
         reopen_dl_ff  <= reopen_dl_in;
         banner_dl_ff  <= banner_dl_in;
         details_dl_ff <= details_dl_in;
         pending_ff    <= pending_in;
      end
   end

   `ASSERT_NEXT(a_take_clears, clock, reset, en && item.command == CMD_TAKE_DIRTY, pending_ff == '0)
   `ASSERT_NEXT(a_refused_sticky, clock, reset, blocked_ff && !(en && item.command == CMD_INIT), blocked_ff)
   `ASSERT_ALWAYS(a_theme_range, clock, reset, theme_ff <= THEME_LAST)

endmodule

### sv/gadget_ui_mode_controller.sv
// Top level of the UI mode controller: input register, core, result register, CSRs.
// Depends on gumc_pkg, gumc_csr, gumc_core and assert_macros.svh.
// Front-panel mode controller. Each command transaction (init, button, tick, song
// ended, song error, take-dirty) yields exactly one result transaction carrying an
// audio request, the repaint flags (take-dirty only, which clears them) and a view of
// the state after the command. Throughput is one transaction per clock cycle while
// rsp_stall is low. A command is accepted into the input register, goes through one
// pass of the update logic and is captured in the result register, which drives the
// rsp_ ports. While a result waits under a stall the result register holds; a command
// already in the input register holds as well and stalls the request side in that same
// cycle, so at most two commands are in flight. The user must write registers
// through the csr_ port only while no command is in flight; the block itself does
// not enforce this.
`include "assert_macros.svh"
module gadget_ui_mode_controller
   import gumc_pkg::*;
#(
   parameter int THEME_COUNT = 4
)(
   input  logic              clock,
   input  logic              reset,
   // Command channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_command,
   input  logic [1:0]        req_button,
   input  logic [31:0]       req_now_ms,
   // Result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_audio_request,
   output logic [5:0]        rsp_repaint_flags,
   output logic              rsp_screen_now,
   output logic [1:0]        rsp_theme_now,
   output logic [1:0]        rsp_song_now,
   output logic              rsp_eye_shut,
   output logic              rsp_start_refused,
   output logic [15:0]       rsp_banner_position,
   // Configuration port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   gumc_cfg_type  cfg;
   gumc_item_type s1_item_ff;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_move;
   gumc_rsp_type  core_rsp;
   gumc_rsp_type  rsp_ff;
   logic          rsp_valid_ff, rsp_valid_in;

   gumc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gumc_core #(
      .THEME_COUNT (THEME_COUNT)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .en    (s1_valid_ff & s1_move),
      .item  (s1_item_ff),
      .rsp   (core_rsp)
   );

   // Advance the input register whenever the result register frees up
   assign s1_move      = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall    = s1_valid_ff & ~s1_move;
   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = s1_move ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the payloads; hold them while stalled
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_item_ff.command <= req_command;
         s1_item_ff.button  <= req_button;
         s1_item_ff.now_ms  <= req_now_ms;
      end
      if (s1_move && s1_valid_ff) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_audio_request   = rsp_ff.audio_request;
   assign rsp_repaint_flags   = rsp_ff.repaint_flags;
   assign rsp_screen_now      = rsp_ff.screen_now;
   assign rsp_theme_now       = rsp_ff.theme_now;
   assign rsp_song_now        = rsp_ff.song_now;
   assign rsp_eye_shut        = rsp_ff.eye_shut;
   assign rsp_start_refused   = rsp_ff.start_refused;
   assign rsp_banner_position = rsp_ff.banner_position;

   `ASSERT_IMPLY(a_stall_needs_item, clock, reset, req_stall, s1_valid_ff)
   `ASSERT_IMPLY(a_result_from_item, clock, reset, $rose(rsp_valid_ff), $past(s1_valid_ff))
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(rsp_ff))

endmodule
